[sv/bltot_pkg.sv]
package bltot_pkg;

   typedef logic [2:0] sensor_type;

   localparam sensor_type SENSOR_NONE  = 3'd0;
   localparam sensor_type SENSOR_FRONT = 3'd1;
   localparam sensor_type SENSOR_RIGHT = 3'd2;
   localparam sensor_type SENSOR_BACK  = 3'd3;
   localparam sensor_type SENSOR_LEFT  = 3'd4;

   localparam int unsigned WAIT_W  = 16;
   localparam int unsigned QUIET_W = 17;
   localparam int unsigned ORDER_W = 13;
   localparam int unsigned ANGLE_W = 10;
   localparam int unsigned CSR_IDX_W = 2;

   typedef logic [WAIT_W-1:0]         wait_type;
   typedef logic [QUIET_W-1:0]        quiet_type;
   typedef logic [ORDER_W-1:0]        order_type;
   typedef logic signed [ANGLE_W-1:0] angle_type;
   typedef logic [CSR_IDX_W-1:0]      csr_idx_type;

   localparam csr_idx_type CSR_WAIT_AFTER_ONE   = 2'd0;
   localparam csr_idx_type CSR_WAIT_AFTER_TWO   = 2'd1;
   localparam csr_idx_type CSR_WAIT_AFTER_THREE = 2'd2;

   localparam wait_type WAIT_AFTER_ONE_RST   = 16'd1;
   localparam wait_type WAIT_AFTER_TWO_RST   = 16'd200;
   localparam wait_type WAIT_AFTER_THREE_RST = 16'd500;

   localparam quiet_type QUIET_MAX = {QUIET_W{1'b1}};

   // Front with back only, right with left only, or all four give this code
   localparam angle_type ANGLE_BAD = 10'sd360;

   // Pattern bits: 0 front, 1 right, 2 back, 3 left
   function automatic angle_type angle_of(input logic [3:0] pattern);
      angle_type a;
      case (pattern)
         4'b0000: a = 10'sd0;
         4'b0001: a = 10'sd0;
         4'b0010: a = -10'sd90;
         4'b0011: a = -10'sd45;
         4'b0100: a = 10'sd180;
         4'b0101: a = ANGLE_BAD;
         4'b0110: a = -10'sd135;
         4'b0111: a = 10'sd0;
         4'b1000: a = 10'sd90;
         4'b1001: a = 10'sd45;
         4'b1010: a = ANGLE_BAD;
         4'b1011: a = 10'sd0;
         4'b1100: a = 10'sd135;
         4'b1101: a = 10'sd90;
         4'b1110: a = 10'sd180;
         default: a = ANGLE_BAD;
      endcase
      return a;
   endfunction

endpackage

[sv/bltot_if.sv]
interface bltot_req_if;
   logic valid;
   logic ready;
   logic front_hit;
   logic right_hit;
   logic back_hit;
   logic left_hit;
   logic ms_tick;

   modport source (output valid, front_hit, right_hit, back_hit, left_hit, ms_tick,
                   input ready);
   modport sink   (input valid, front_hit, right_hit, back_hit, left_hit, ms_tick,
                   output ready);
endinterface

interface bltot_rsp_if import bltot_pkg::*;;
   logic       valid;
   logic       ready;
   sensor_type first_sensor;
   sensor_type second_sensor;
   sensor_type third_sensor;
   order_type  order_code;
   logic       out_flag;
   angle_type  line_angle;

   modport source (output valid, first_sensor, second_sensor, third_sensor, order_code,
                          out_flag, line_angle,
                   input ready);
   modport sink   (input valid, first_sensor, second_sensor, third_sensor, order_code,
                         out_flag, line_angle,
                   output ready);
endinterface

interface bltot_csr_if import bltot_pkg::*;;
   logic        valid;
   logic        ready;
   csr_idx_type index;
   wait_type    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[sv/boundary_line_touch_order_tracker_core.sv]
// Boundary-line touch order tracker. Each request is one sample of the four
// line sensors plus a millisecond tick; each request gives exactly one
// response with the first, second and third sensor touched, the order code
// (1000*first + 100*second + 10*third), an any-active flag and the direction
// code of the active pattern. A request is taken every clock cycle while the
// response register is empty or being drained, and its response appears in
// the next cycle; the whole update is one pass of shallow logic into that
// register. After a quiet spell longer than the wait selected by the number
// of recorded stages, the recorded order clears. The three wait registers
// (indexes 0, 1, 2) are written through the csr channel, which never stalls.
module boundary_line_touch_order_tracker_core import bltot_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   bltot_req_if.sink      req_bus,
   bltot_rsp_if.source    rsp_bus,
   bltot_csr_if.sink      csr_bus
);

   wait_type   wait_one_ff, wait_two_ff, wait_three_ff;
   sensor_type first_ff, second_ff, third_ff;
   sensor_type first_in, second_in, third_in;
   quiet_type  quiet_ff, quiet_in, quiet_inc;
   wait_type   wait_sel;

   logic       rsp_valid_ff;
   sensor_type rsp_first_ff, rsp_second_ff, rsp_third_ff;
   order_type  rsp_order_ff, order_in;
   logic       rsp_flag_ff;
   angle_type  rsp_angle_ff;

   logic [3:0] pattern;
   logic       any_hit;
   logic       req_fire;

   // Highest-numbered active sensor other than a and b
   function automatic sensor_type pick_new(input logic [3:0] act,
                                           input sensor_type a,
                                           input sensor_type b);
      sensor_type win;
      sensor_type k;
      win = SENSOR_NONE;
      for (int i = 0; i < 4; i++) begin
         k = sensor_type'(i + 1);
         if (act[i] && k != a && k != b) begin
            win = k;
         end
      end
      return win;
   endfunction

   assign pattern  = {req_bus.left_hit, req_bus.back_hit, req_bus.right_hit,
                      req_bus.front_hit};
   assign any_hit  = |pattern;
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_fire = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   always_comb begin
      first_in  = first_ff;
      second_in = second_ff;
      third_in  = third_ff;
      quiet_in  = quiet_ff;
      quiet_inc = quiet_ff;
      if (req_bus.ms_tick && quiet_ff != QUIET_MAX) begin
         quiet_inc = quiet_ff + quiet_type'(1);
      end
      if (second_ff == SENSOR_NONE) begin
         wait_sel = wait_one_ff;
      end else if (third_ff == SENSOR_NONE) begin
         wait_sel = wait_two_ff;
      end else begin
         wait_sel = wait_three_ff;
      end
      if (any_hit) begin
         quiet_in = '0;
         if (first_ff == SENSOR_NONE) begin
            first_in  = pick_new(pattern, SENSOR_NONE, SENSOR_NONE);
            second_in = SENSOR_NONE;
            third_in  = SENSOR_NONE;
         end else if (second_ff == SENSOR_NONE) begin
            second_in = pick_new(pattern, first_ff, SENSOR_NONE);
         end else if (third_ff == SENSOR_NONE) begin
            third_in = pick_new(pattern, first_ff, second_ff);
         end
      end else begin
         quiet_in = quiet_inc;
         // Drop the recorded order once the quiet time passes the wait
         if (quiet_inc > {1'b0, wait_sel}) begin
            first_in  = SENSOR_NONE;
            second_in = SENSOR_NONE;
            third_in  = SENSOR_NONE;
         end
      end
      order_in = order_type'(ORDER_W'(first_in) * ORDER_W'(1000))
               + order_type'(ORDER_W'(second_in) * ORDER_W'(100))
               + order_type'(ORDER_W'(third_in) * ORDER_W'(10));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wait_one_ff   <= WAIT_AFTER_ONE_RST;
         wait_two_ff   <= WAIT_AFTER_TWO_RST;
         wait_three_ff <= WAIT_AFTER_THREE_RST;
         first_ff      <= SENSOR_NONE;
         second_ff     <= SENSOR_NONE;
         third_ff      <= SENSOR_NONE;
         quiet_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_bus.valid) begin
            case (csr_bus.index)
               CSR_WAIT_AFTER_ONE:   wait_one_ff   <= csr_bus.data;
               CSR_WAIT_AFTER_TWO:   wait_two_ff   <= csr_bus.data;
               CSR_WAIT_AFTER_THREE: wait_three_ff <= csr_bus.data;
               default: ;
            endcase
         end
         if (req_fire) begin
            first_ff     <= first_in;
            second_ff    <= second_in;
            third_ff     <= third_in;
            quiet_ff     <= quiet_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_first_ff  <= first_in;
         rsp_second_ff <= second_in;
         rsp_third_ff  <= third_in;
         rsp_order_ff  <= order_in;
         rsp_flag_ff   <= any_hit;
         rsp_angle_ff  <= angle_of(pattern);
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.first_sensor  = rsp_first_ff;
   assign rsp_bus.second_sensor = rsp_second_ff;
   assign rsp_bus.third_sensor  = rsp_third_ff;
   assign rsp_bus.order_code    = rsp_order_ff;
   assign rsp_bus.out_flag      = rsp_flag_ff;
   assign rsp_bus.line_angle    = rsp_angle_ff;

endmodule

[tb/testbench.sv]
module testbench import bltot_pkg::*;;

   localparam int IDLE_LIMIT  = 1000;
   localparam int HOLD_OFF    = 64;
   localparam int HOLD_OFF_AT = 300;

   typedef struct packed {
      sensor_type first_sensor;
      sensor_type second_sensor;
      sensor_type third_sensor;
      order_type  order_code;
      logic       out_flag;
      angle_type  line_angle;
   } touch_report;

   // hits: bit 0 front, 1 right, 2 back, 3 left
   typedef struct packed {
      logic [3:0]  hits;
      logic        tick;
      logic        typed;
      touch_report want;
   } directed_row;

   logic clock;
   logic reset = 1'b1;

   bltot_req_if req_bus ();
   bltot_rsp_if rsp_bus ();
   bltot_csr_if csr_bus ();

   boundary_line_touch_order_tracker_core uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Tracker state as the testbench sees it
   sensor_type seen_first;
   sensor_type seen_second;
   sensor_type seen_third;
   quiet_type  quiet_ticks;
   order_type  order_sum;
   wait_type   quiet_limit_one;
   wait_type   quiet_limit_two;
   wait_type   quiet_limit_three;

   touch_report pending_reports [$];
   int          mismatches = 0;
   logic        gaps_off = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      $display("MISMATCH: %s", what);
      mismatches++;
   endtask

   function automatic sensor_type newest_unrecorded(input logic [3:0] hits,
                                                    input sensor_type a,
                                                    input sensor_type b);
      sensor_type win;
      win = SENSOR_NONE;
      for (int k = SENSOR_FRONT; k <= SENSOR_LEFT; k++) begin
         if (hits[k-1] && sensor_type'(k) != a && sensor_type'(k) != b)
            win = sensor_type'(k);
      end
      return win;
   endfunction

   function automatic angle_type direction_of(input logic [3:0] hits);
      int deg;
      case (hits)
         4'b0010: deg = -90;
         4'b0011: deg = -45;
         4'b0100: deg = 180;
         4'b0110: deg = -135;
         4'b1000: deg = 90;
         4'b1001: deg = 45;
         4'b1100: deg = 135;
         4'b1101: deg = 90;
         4'b1110: deg = 180;
         4'b0101, 4'b1010, 4'b1111: deg = 360;
         default: deg = 0;
      endcase
      return angle_type'(deg);
   endfunction

   function automatic touch_report predict_touch(input logic [3:0] hits, input logic tick);
      touch_report r;
      wait_type    limit;
      if (hits != 4'b0000) begin
         if (seen_first == SENSOR_NONE) begin
            seen_first  = newest_unrecorded(hits, SENSOR_NONE, SENSOR_NONE);
            seen_second = SENSOR_NONE;
            seen_third  = SENSOR_NONE;
            order_sum   = order_type'(int'(seen_first) * 1000);
         end else if (seen_second == SENSOR_NONE) begin
            seen_second = newest_unrecorded(hits, seen_first, SENSOR_NONE);
            order_sum   = order_type'(int'(order_sum) + int'(seen_second) * 100);
         end else if (seen_third == SENSOR_NONE) begin
            seen_third = newest_unrecorded(hits, seen_first, seen_second);
            order_sum  = order_type'(int'(order_sum) + int'(seen_third) * 10);
         end
         quiet_ticks = '0;
      end else begin
         if (tick && quiet_ticks != QUIET_MAX)
            quiet_ticks++;
         if (seen_second == SENSOR_NONE)
            limit = quiet_limit_one;
         else if (seen_third == SENSOR_NONE)
            limit = quiet_limit_two;
         else
            limit = quiet_limit_three;
         if (quiet_ticks > {1'b0, limit}) begin
            seen_first  = SENSOR_NONE;
            seen_second = SENSOR_NONE;
            seen_third  = SENSOR_NONE;
            order_sum   = '0;
         end
      end
      r.first_sensor  = seen_first;
      r.second_sensor = seen_second;
      r.third_sensor  = seen_third;
      r.order_code    = order_sum;
      r.out_flag      = |hits;
      r.line_angle    = direction_of(hits);
      return r;
   endfunction

   function automatic directed_row make_row(input logic [3:0] hits, input int tick,
                                            input int typed, input sensor_type f,
                                            input sensor_type s, input sensor_type t,
                                            input int order, input int flag,
                                            input int angle);
      directed_row row;
      row.hits               = hits;
      row.tick               = 1'(tick);
      row.typed              = 1'(typed);
      row.want.first_sensor  = f;
      row.want.second_sensor = s;
      row.want.third_sensor  = t;
      row.want.order_code    = order_type'(order);
      row.want.out_flag      = 1'(flag);
      row.want.line_angle    = angle_type'(angle);
      return row;
   endfunction

   function automatic wait_type pick_wait();
      if ($urandom_range(0, 3) == 0)
         return wait_type'($urandom_range(0, 65535));
      return wait_type'($urandom_range(0, 10));
   endfunction

   // Leaves valid high after the handshake so a back-to-back request needs no toggle
   task automatic send_sample(input logic [3:0] hits, input logic tick,
                              input logic typed, input touch_report typed_want);
      int          gap;
      touch_report predicted;
      gap = gaps_off ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.front_hit <= hits[0];
      req_bus.right_hit <= hits[1];
      req_bus.back_hit  <= hits[2];
      req_bus.left_hit  <= hits[3];
      req_bus.ms_tick   <= tick;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      predicted = predict_touch(hits, tick);
      pending_reports.push_back(typed ? typed_want : predicted);
   endtask

   task automatic write_wait(input csr_idx_type idx, input wait_type value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!(csr_bus.valid && csr_bus.ready));
      case (idx)
         CSR_WAIT_AFTER_ONE:   quiet_limit_one   = value;
         CSR_WAIT_AFTER_TWO:   quiet_limit_two   = value;
         CSR_WAIT_AFTER_THREE: quiet_limit_three = value;
         default: ;
      endcase
   endtask

   task automatic program_waits(input wait_type one, input wait_type two,
                                input wait_type three);
      write_wait(CSR_WAIT_AFTER_ONE, one);
      write_wait(CSR_WAIT_AFTER_TWO, two);
      write_wait(CSR_WAIT_AFTER_THREE, three);
      csr_bus.valid <= 1'b0;
   endtask

   // Mostly touch bursts followed by quiet spells, with some raw noise mixed in
   task automatic run_random(input int count);
      int         touch_run;
      int         quiet_run;
      logic [3:0] hits;
      logic       tick;
      touch_run = 0;
      quiet_run = 0;
      repeat (count) begin
         if ($urandom_range(0, 9) == 0) begin
            hits = 4'($urandom_range(0, 15));
            tick = 1'($urandom_range(0, 1));
         end else if (touch_run > 0) begin
            hits = 4'($urandom_range(1, 15));
            tick = 1'($urandom_range(0, 1));
            touch_run--;
         end else if (quiet_run > 0) begin
            hits = 4'b0000;
            tick = ($urandom_range(0, 3) != 0);
            quiet_run--;
         end else begin
            touch_run = $urandom_range(0, 3);
            quiet_run = $urandom_range(0, 14);
            hits = 4'($urandom_range(1, 15));
            tick = 1'($urandom_range(0, 1));
         end
         send_sample(hits, tick, 1'b0, '0);
      end
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      directed_row rows [24];
      req_bus.valid     <= 1'b0;
      req_bus.front_hit <= 1'b0;
      req_bus.right_hit <= 1'b0;
      req_bus.back_hit  <= 1'b0;
      req_bus.left_hit  <= 1'b0;
      req_bus.ms_tick   <= 1'b0;
      csr_bus.valid     <= 1'b0;
      csr_bus.index     <= CSR_WAIT_AFTER_ONE;
      csr_bus.data      <= '0;

      seen_first        = SENSOR_NONE;
      seen_second       = SENSOR_NONE;
      seen_third        = SENSOR_NONE;
      quiet_ticks       = '0;
      order_sum         = '0;
      quiet_limit_one   = WAIT_AFTER_ONE_RST;
      quiet_limit_two   = WAIT_AFTER_TWO_RST;
      quiet_limit_three = WAIT_AFTER_THREE_RST;

      // quiet right after reset, then a lone left touch that times out
      rows[0]  = make_row(4'b0000, 1, 1, SENSOR_NONE, SENSOR_NONE, SENSOR_NONE, 0, 0, 0);
      rows[1]  = make_row(4'b0000, 1, 1, SENSOR_NONE, SENSOR_NONE, SENSOR_NONE, 0, 0, 0);
      rows[2]  = make_row(4'b1000, 0, 1, SENSOR_LEFT, SENSOR_NONE, SENSOR_NONE, 4000, 1, 90);
      rows[3]  = make_row(4'b0000, 1, 0, SENSOR_NONE, SENSOR_NONE, SENSOR_NONE, 0, 0, 0);
      rows[4]  = make_row(4'b0000, 0, 0, SENSOR_NONE, SENSOR_NONE, SENSOR_NONE, 0, 0, 0);
      rows[5]  = make_row(4'b0000, 1, 0, SENSOR_NONE, SENSOR_NONE, SENSOR_NONE, 0, 0, 0);
      // front twice: the second stage finds nothing new and stays open
      rows[6]  = make_row(4'b0001, 0, 0, SENSOR_NONE, SENSOR_NONE, SENSOR_NONE, 0, 0, 0);
      rows[7]  = make_row(4'b0001, 1, 0, SENSOR_NONE, SENSOR_NONE, SENSOR_NONE, 0, 0, 0);
      rows[8]  = make_row(4'b0110, 0, 0, SENSOR_NONE, SENSOR_NONE, SENSOR_NONE, 0, 0, 0);
      rows[9]  = make_row(4'b0110, 0, 0, SENSOR_NONE, SENSOR_NONE, SENSOR_NONE, 0, 0, 0);
      // all stages filled from here on; walk the remaining patterns
      rows[10] = make_row(4'b1000, 0, 0, SENSOR_NONE, SENSOR_NONE, SENSOR_NONE, 0, 0, 0);
      rows[11] = make_row(4'b0101, 0, 1, SENSOR_FRONT, SENSOR_BACK, SENSOR_RIGHT,
                          1320, 1, 360);
      rows[12] = make_row(4'b1010, 1, 1, SENSOR_FRONT, SENSOR_BACK, SENSOR_RIGHT,
                          1320, 1, 360);
      rows[13] = make_row(4'b0010, 0, 0, SENSOR_NONE, SENSOR_NONE, SENSOR_NONE, 0, 0, 0);
      rows[14] = make_row(4'b0100, 1, 0, SENSOR_NONE, SENSOR_NONE, SENSOR_NONE, 0, 0, 0);
      rows[15] = make_row(4'b1001, 0, 0, SENSOR_NONE, SENSOR_NONE, SENSOR_NONE, 0, 0, 0);
      rows[16] = make_row(4'b0111, 0, 0, SENSOR_NONE, SENSOR_NONE, SENSOR_NONE, 0, 0, 0);
      rows[17] = make_row(4'b1011, 1, 0, SENSOR_NONE, SENSOR_NONE, SENSOR_NONE, 0, 0, 0);
      rows[18] = make_row(4'b1100, 0, 0, SENSOR_NONE, SENSOR_NONE, SENSOR_NONE, 0, 0, 0);
      rows[19] = make_row(4'b1101, 0, 0, SENSOR_NONE, SENSOR_NONE, SENSOR_NONE, 0, 0, 0);
      rows[20] = make_row(4'b1110, 1, 0, SENSOR_NONE, SENSOR_NONE, SENSOR_NONE, 0, 0, 0);
      rows[21] = make_row(4'b0000, 1, 0, SENSOR_NONE, SENSOR_NONE, SENSOR_NONE, 0, 0, 0);
      rows[22] = make_row(4'b0011, 0, 0, SENSOR_NONE, SENSOR_NONE, SENSOR_NONE, 0, 0, 0);
      rows[23] = make_row(4'b1111, 1, 1, SENSOR_FRONT, SENSOR_BACK, SENSOR_RIGHT,
                          1320, 1, 360);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int k = 0; k < 24; k++)
         send_sample(rows[k].hits, rows[k].tick, rows[k].typed, rows[k].want);
      settle();

      // zero waits: any tick on a quiet sample clears
      program_waits('0, '0, '0);
      run_random(100);
      settle();

      // full-scale waits: fill all stages and hold a long quiet spell
      program_waits('1, '1, '1);
      run_random(60);
      gaps_off = 1'b1;
      repeat (3) send_sample(4'b1111, 1'($urandom_range(0, 1)), 1'b0, '0);
      repeat (100) send_sample(4'b0000, 1'b1, 1'b0, '0);
      send_sample(4'b0000, 1'b0, 1'b0, '0);
      gaps_off = 1'b0;
      settle();

      for (int p = 0; p < 6; p++) begin
         gaps_off = ($urandom_range(0, 3) == 0);
         program_waits(pick_wait(), pick_wait(), pick_wait());
         run_random(110);
         settle();
      end

      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin : drain_responses
      int gap;
      int taken;
      taken = 0;
      rsp_bus.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         gap = gaps_off ? 0 : $urandom_range(0, 3);
         // stall once for a long stretch so the block backs up into its input
         if (taken == HOLD_OFF_AT)
            gap = HOLD_OFF;
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
         taken++;
      end
   end

   task automatic check_field(input int index, input string name, input int got,
                              input int want);
      if (got != want)
         report_mismatch($sformatf("response %0d %s got %0d expected %0d",
                                   index, name, got, want));
   endtask

   always @(posedge clock) begin : check_responses
      touch_report want;
      int          index;
      if (reset) begin
         index = 0;
      end else if (rsp_bus.valid && rsp_bus.ready) begin
         if (pending_reports.size() == 0) begin
            report_mismatch($sformatf("response %0d arrived with no request pending", index));
         end else begin
            want = pending_reports.pop_front();
            check_field(index, "first_sensor", int'(rsp_bus.first_sensor),
                        int'(want.first_sensor));
            check_field(index, "second_sensor", int'(rsp_bus.second_sensor),
                        int'(want.second_sensor));
            check_field(index, "third_sensor", int'(rsp_bus.third_sensor),
                        int'(want.third_sensor));
            check_field(index, "order_code", int'(rsp_bus.order_code),
                        int'(want.order_code));
            check_field(index, "out_flag", int'(rsp_bus.out_flag), int'(want.out_flag));
            check_field(index, "line_angle", int'($signed(rsp_bus.line_angle)),
                        int'($signed(want.line_angle)));
         end
         index++;
      end
   end

   always @(posedge clock) begin : watchdog
      int idle;
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         idle = 0;
      end else begin
         idle++;
         if (idle >= IDLE_LIMIT) begin
            $display("watchdog: no request or response moved in %0d cycles", idle);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

endmodule
